// ===== hw/rtl/multi_slot_software_timer_table_assert.svh =====
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Shared assertion forms for the timer table checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_TABLE_ASSERT_SVH

// plain property, sampled on clk, off during reset
`define MSTT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// stalled result word must stay valid and unchanged
`define MSTT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (m_tvalid && $stable(m_tdata))) else $error(msg);

`endif

// ===== hw/rtl/mstt_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, action and run-state codes and shared types for the timer table.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W    = $clog2(SLOTS + 1);
    localparam int ID_W     = 32;
    localparam int TICK_W   = 32;
    localparam int LIVE_W   = 5;
    localparam int ACT_W    = 3;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 40;
    localparam int M_PAD_W  = M_DATA_W - 1 - ID_W - LIVE_W;

    // action codes
    localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PAUSE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd5;

    // run states
    localparam logic [1:0] RUN_IDLE   = 2'd0;
    localparam logic [1:0] RUN_ACTIVE = 2'd1;
    localparam logic [1:0] RUN_PAUSED = 2'd2;

    // one slot record as held in the slot RAM
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] interval;
        logic [TICK_W-1:0] remaining;
        logic              periodic;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    // one result word
    typedef struct packed {
        logic              kind;
        logic              success;
        logic [ID_W-1:0]   reply_id;
        logic [LIVE_W-1:0] live_count;
        logic              last;
    } result_t;

    // controller to output stage
    typedef struct packed {
        logic    load;
        result_t item;
    } res_push_t;

endpackage

// ===== hw/rtl/multi_slot_software_timer_table.sv =====
// ----------------------------------------------------------------------------
// Multi-slot software timer table
// Table of one-shot and periodic timers driven by create, start, pause,
// cancel, update and count actions.
// ----------------------------------------------------------------------------
// Create, count and unknown actions go straight to the finish state. Start,
// pause and cancel search the age list newest first through the slot RAM,
// one RAM read and one compare per slot visited. Update visits every live
// timer once (RAM read, then compare and write back), and waits whenever an
// expiry word or the final word finds the output stage stalled. One action
// is handled at a time; the next is taken while the final result word still
// waits in the output register.
module multi_slot_software_timer_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // target_id[31:0], period[63:32], periodic[64], elapsed_ticks[96:65]
    input  logic [mstt_pkg::S_DATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [mstt_pkg::ACT_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // success[0], reply_id[32:1], live_count[37:33]
    output logic [mstt_pkg::M_DATA_W-1:0] m_tdata,
    // result_kind
    output logic                          m_tuser,
    // last_item
    output logic                          m_tlast
);
    import mstt_pkg::*;

    res_push_t push;
    logic      out_free;

    mstt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .push      (push),
        .out_free  (out_free)
    );

    mstt_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/mstt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mstt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Timer table controller
// Age-ordered slot list, per-slot flags and the sequencer that walks the
// slot RAM for lookups and updates.
// ----------------------------------------------------------------------------
module mstt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mstt_pkg::ACT_W-1:0]    in_action,
    input  logic [mstt_pkg::S_DATA_W-1:0] in_data,
    output mstt_pkg::res_push_t           push,
    input  logic                          out_free
);
    import mstt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_CHECK  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ID_W-1:0]   target_reg, target_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]  order_reg [SLOTS];
    logic [IDX_W-1:0]  order_next [SLOTS];
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  wr_reg, wr_next;
    logic [SLOTS-1:0]  used_reg, used_next;
    logic [1:0]        run_reg [SLOTS];
    logic [1:0]        run_next [SLOTS];
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic              fin_ok_reg, fin_ok_next;
    logic [ID_W-1:0]   fin_id_reg, fin_id_next;
    logic [LIVE_W-1:0] fin_cnt_reg, fin_cnt_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_rec_t         ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    slot_rec_t         ram_rdata;

    logic [TICK_W-1:0] in_target, in_period, in_elapsed;
    logic              in_periodic;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  cur_slot;
    logic [LEN_W-1:0]  pos_inc;
    logic [ID_W-1:0]   id_inc;
    logic              expire;
    logic              keep;

    mstt_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // input word fields
    assign in_target   = in_data[31:0];
    assign in_period   = in_data[63:32];
    assign in_periodic = in_data[64];
    assign in_elapsed  = in_data[96:65];

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!used_reg[s])
            begin
                free_idx = IDX_W'(s);
            end
        end
    end

    assign cur_slot = order_reg[pos_reg[IDX_W-1:0]];
    assign pos_inc  = pos_reg + LEN_W'(1);
    assign id_inc   = next_id_reg + ID_W'(1);
    assign in_ready = (state_reg == ST_IDLE);
    assign expire   = (run_reg[cur_slot] == RUN_ACTIVE)
                   && (ram_rdata.remaining <= elapsed_reg);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        order_next   = order_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        wr_next      = wr_reg;
        used_next    = used_reg;
        run_next     = run_reg;
        next_id_next = next_id_reg;
        fin_ok_next  = fin_ok_reg;
        fin_id_next  = fin_id_reg;
        fin_cnt_next = fin_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = cur_slot;
        ram_wdata    = ram_rdata;
        ram_raddr    = cur_slot;
        push         = '0;
        keep         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = in_action;
                    target_next  = in_target;
                    elapsed_next = in_elapsed;
                    pos_next     = '0;
                    wr_next      = '0;
                    fin_ok_next  = 1'b0;
                    fin_id_next  = '0;
                    fin_cnt_next = '0;
                    state_next   = ST_FINISH;
                    case (in_action) inside
                        ACT_CREATE:
                        begin
                            if (in_period != '0 && len_reg != LEN_W'(SLOTS))
                            begin
                                ram_we               = 1'b1;
                                ram_waddr            = free_idx;
                                ram_wdata.id         = next_id_reg;
                                ram_wdata.interval   = in_period;
                                ram_wdata.remaining  = in_period;
                                ram_wdata.periodic   = in_periodic;
                                used_next[free_idx]  = 1'b1;
                                run_next[free_idx]   = RUN_IDLE;
                                for (int k = SLOTS - 1; k > 0; k--)
                                begin
                                    order_next[k] = order_reg[k-1];
                                end
                                order_next[0] = free_idx;
                                len_next      = len_reg + LEN_W'(1);
                                fin_ok_next   = 1'b1;
                                fin_id_next   = next_id_reg;
                                next_id_next  = (id_inc == '0) ? ID_W'(1) : id_inc;
                            end
                        end
                        ACT_START, ACT_PAUSE, ACT_CANCEL, ACT_UPDATE:
                        begin
                            if (len_reg != '0)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        ACT_COUNT:
                        begin
                            fin_cnt_next = LIVE_W'(len_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (act_reg == ACT_UPDATE)
                begin
                    // expiry waits for room in the output stage
                    if (!expire || out_free)
                    begin
                        if (run_reg[cur_slot] != RUN_ACTIVE)
                        begin
                            keep = 1'b1;
                        end
                        else if (expire)
                        begin
                            push.load            = 1'b1;
                            push.item.kind       = 1'b1;
                            push.item.reply_id   = ram_rdata.id;
                            if (ram_rdata.periodic)
                            begin
                                keep                = 1'b1;
                                ram_we              = 1'b1;
                                ram_wdata.remaining = ram_rdata.interval;
                            end
                            else
                            begin
                                used_next[cur_slot] = 1'b0;
                            end
                        end
                        else
                        begin
                            keep                = 1'b1;
                            ram_we              = 1'b1;
                            ram_wdata.remaining = ram_rdata.remaining - elapsed_reg;
                        end
                        // compact the age list in place
                        if (keep)
                        begin
                            order_next[wr_reg[IDX_W-1:0]] = cur_slot;
                            wr_next = wr_reg + LEN_W'(1);
                        end
                        pos_next = pos_inc;
                        if (pos_inc == len_reg)
                        begin
                            len_next   = wr_reg + LEN_W'(keep);
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
                else if (ram_rdata.id == target_reg)
                begin
                    // newest timer with this id
                    state_next = ST_FINISH;
                    case (act_reg)
                        ACT_START:
                        begin
                            if (run_reg[cur_slot] != RUN_ACTIVE)
                            begin
                                run_next[cur_slot] = RUN_ACTIVE;
                                fin_ok_next        = 1'b1;
                            end
                        end
                        ACT_PAUSE:
                        begin
                            if (run_reg[cur_slot] == RUN_ACTIVE)
                            begin
                                run_next[cur_slot] = RUN_PAUSED;
                                fin_ok_next        = 1'b1;
                            end
                        end
                        default:
                        begin
                            used_next[cur_slot] = 1'b0;
                            for (int k = 0; k < SLOTS - 1; k++)
                            begin
                                if (LEN_W'(k) >= pos_reg)
                                begin
                                    order_next[k] = order_reg[k+1];
                                end
                            end
                            len_next    = len_reg - LEN_W'(1);
                            fin_ok_next = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = (pos_inc == len_reg) ? ST_FINISH : ST_READ;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    push.load            = 1'b1;
                    push.item.success    = fin_ok_reg;
                    push.item.reply_id   = fin_id_reg;
                    push.item.live_count = fin_cnt_reg;
                    push.item.last       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            used_reg    <= '0;
            next_id_reg <= ID_W'(1);
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            used_reg    <= used_next;
            next_id_reg <= next_id_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        target_reg  <= target_next;
        elapsed_reg <= elapsed_next;
        order_reg   <= order_next;
        pos_reg     <= pos_next;
        wr_reg      <= wr_next;
        run_reg     <= run_next;
        fin_ok_reg  <= fin_ok_next;
        fin_id_reg  <= fin_id_next;
        fin_cnt_reg <= fin_cnt_next;
    end

endmodule

// ===== hw/rtl/mstt_out.sv =====
// ----------------------------------------------------------------------------
// Timer table output stage
// Result word register between the sequencer and the master stream.
// ----------------------------------------------------------------------------
module mstt_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mstt_pkg::res_push_t           push,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mstt_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import mstt_pkg::*;

    logic    valid_reg, valid_next;
    result_t item_reg, item_next;

    assign free = !valid_reg || m_tready;

    // load on push, drain on handshake
    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (push.load)
        begin
            valid_next = 1'b1;
            item_next  = push.item;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, item_reg.live_count, item_reg.reply_id,
                       item_reg.success};
    assign m_tuser  = item_reg.kind;
    assign m_tlast  = item_reg.last;

endmodule

// ===== hw/rtl/mstt_checker.sv =====
// ----------------------------------------------------------------------------
// Timer table checker
// Port-level assertions on the result stream of the timer table.
// ----------------------------------------------------------------------------
`include "multi_slot_software_timer_table_assert.svh"

module mstt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mstt_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    `MSTT_HOLD(a_stall_hold, m_tvalid && !m_tready,
        "result word changed while stalled")
    `MSTT_CHECK(a_expiry_not_last, (m_tvalid && m_tuser) |-> !m_tlast,
        "expiry word marked last")
    `MSTT_CHECK(a_expiry_fields,
        (m_tvalid && m_tuser) |-> (m_tdata[0] == 1'b0 && m_tdata[37:33] == 5'd0),
        "expiry word with success or count")
    `MSTT_CHECK(a_pad_zero, m_tvalid |-> (m_tdata[39:38] == 2'b00),
        "result padding not zero")

endmodule

bind multi_slot_software_timer_table mstt_checker u_checker (.*);

// ===== dv/tb_multi_slot_software_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table testbench
// Drives create, start, pause, cancel, update and count actions into the
// timer table over the slave stream and checks every result word against
// an in-bench model of the slot table. Random idling is applied on both
// stream sides in two of the three random phases.
// ----------------------------------------------------------------------------
module tb_multi_slot_software_timer_table;

    import mstt_pkg::*;

    // spare action codes, answered with a bare reply
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;
    localparam int RUN_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [ACT_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    multi_slot_software_timer_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock, 10 ns
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // timer table shadow
    logic              tmr_used     [SLOTS];
    logic [ID_W-1:0]   tmr_id       [SLOTS];
    logic [TICK_W-1:0] tmr_interval [SLOTS];
    logic [TICK_W-1:0] tmr_left     [SLOTS];
    logic              tmr_periodic [SLOTS];
    logic [1:0]        tmr_state    [SLOTS];
    int                tmr_rank     [SLOTS];
    logic [ID_W-1:0]   next_id;

    result_t pending_words[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      cycle_count;

    function automatic void push_word(logic k, logic ok, logic [ID_W-1:0] rid,
                                      logic [LIVE_W-1:0] cnt, logic lst);
        result_t w;
        w.kind       = k;
        w.success    = ok;
        w.reply_id   = rid;
        w.live_count = cnt;
        w.last       = lst;
        pending_words.push_back(w);
    endfunction

    // work out the words one action produces and update the shadow table
    function automatic void model_action(logic [ACT_W-1:0] act, logic [ID_W-1:0] tgt,
                                         logic [TICK_W-1:0] per, logic pf,
                                         logic [TICK_W-1:0] el);
        int free_s;
        int hit;
        int cnt;
        int n;
        int nr;
        int dropped;
        int order[SLOTS];
        logic ok;
        free_s = -1;
        hit = -1;
        cnt = 0;
        n = 0;
        nr = 0;
        ok = 1'b0;
        case (act) inside
            ACT_CREATE:
            begin
                for (int s = SLOTS - 1; s >= 0; s--)
                    if (!tmr_used[s])
                        free_s = s;
                if (per == '0 || free_s < 0)
                    push_word(1'b0, 1'b0, '0, '0, 1'b1);
                else
                begin
                    for (int s = 0; s < SLOTS; s++)
                        if (tmr_used[s])
                            tmr_rank[s]++;
                    tmr_used[free_s]     = 1'b1;
                    tmr_id[free_s]       = next_id;
                    tmr_interval[free_s] = per;
                    tmr_left[free_s]     = per;
                    tmr_periodic[free_s] = pf;
                    tmr_state[free_s]    = RUN_IDLE;
                    tmr_rank[free_s]     = 0;
                    push_word(1'b0, 1'b1, next_id, '0, 1'b1);
                    next_id = next_id + 1;
                    if (next_id == '0)
                        next_id = 1;
                end
            end
            ACT_START, ACT_PAUSE, ACT_CANCEL:
            begin
                // newest timer holding the id
                for (int s = 0; s < SLOTS; s++)
                    if (tmr_used[s] && tmr_id[s] == tgt)
                        if (hit < 0 || tmr_rank[s] < tmr_rank[hit])
                            hit = s;
                if (hit >= 0)
                begin
                    if (act == ACT_START && tmr_state[hit] != RUN_ACTIVE)
                    begin
                        tmr_state[hit] = RUN_ACTIVE;
                        ok = 1'b1;
                    end
                    else if (act == ACT_PAUSE && tmr_state[hit] == RUN_ACTIVE)
                    begin
                        tmr_state[hit] = RUN_PAUSED;
                        ok = 1'b1;
                    end
                    else if (act == ACT_CANCEL)
                    begin
                        dropped = tmr_rank[hit];
                        tmr_used[hit] = 1'b0;
                        for (int s = 0; s < SLOTS; s++)
                            if (tmr_used[s] && tmr_rank[s] > dropped)
                                tmr_rank[s]--;
                        ok = 1'b1;
                    end
                end
                push_word(1'b0, ok, '0, '0, 1'b1);
            end
            ACT_UPDATE:
            begin
                for (int r = 0; r < SLOTS; r++)
                    for (int s = 0; s < SLOTS; s++)
                        if (tmr_used[s] && tmr_rank[s] == r)
                        begin
                            order[n] = s;
                            n++;
                        end
                for (int i = 0; i < n; i++)
                begin
                    if (tmr_state[order[i]] == RUN_ACTIVE)
                    begin
                        if (tmr_left[order[i]] <= el)
                        begin
                            push_word(1'b1, 1'b0, tmr_id[order[i]], '0, 1'b0);
                            if (tmr_periodic[order[i]])
                                tmr_left[order[i]] = tmr_interval[order[i]];
                            else
                                tmr_used[order[i]] = 1'b0;
                        end
                        else
                            tmr_left[order[i]] = tmr_left[order[i]] - el;
                    end
                end
                for (int i = 0; i < n; i++)
                    if (tmr_used[order[i]])
                    begin
                        tmr_rank[order[i]] = nr;
                        nr++;
                    end
                push_word(1'b0, 1'b0, '0, '0, 1'b1);
            end
            ACT_COUNT:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (tmr_used[s])
                        cnt++;
                push_word(1'b0, 1'b0, '0, LIVE_W'(cnt), 1'b1);
            end
            default:
                push_word(1'b0, 1'b0, '0, '0, 1'b1);
        endcase
    endfunction

    // an id held by a random live timer, or a random id if none
    function automatic logic [ID_W-1:0] live_id();
        logic [ID_W-1:0] ids[$];
        for (int s = 0; s < SLOTS; s++)
            if (tmr_used[s])
                ids.push_back(tmr_id[s]);
        if (ids.size() == 0)
            return $urandom;
        return ids[$urandom_range(ids.size() - 1)];
    endfunction

    // send one word; called and returns at a falling edge
    task automatic send_word(logic [ACT_W-1:0] act, logic [ID_W-1:0] tgt,
                             logic [TICK_W-1:0] per, logic pf, logic [TICK_W-1:0] el);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {7'b0, el, pf, per, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        model_action(act, tgt, per, pf, el);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // hold off until every pending word has come back
    task automatic drain();
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind       = m_tuser;
            got.success    = m_tdata[0];
            got.reply_id   = m_tdata[32:1];
            got.live_count = m_tdata[37:33];
            got.last       = m_tlast;
            if (pending_words.size() == 0)
            begin
                $error("result word with nothing pending");
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                    fail_count++;
                end
                if (got.success !== want.success)
                begin
                    $error("success: expected %0d, got %0d", want.success, got.success);
                    fail_count++;
                end
                if (got.reply_id !== want.reply_id)
                begin
                    $error("reply_id: expected %0d, got %0d", want.reply_id, got.reply_id);
                    fail_count++;
                end
                if (got.live_count !== want.live_count)
                begin
                    $error("live_count: expected %0d, got %0d",
                           want.live_count, got.live_count);
                    fail_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_item: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("multi_slot_software_timer_table verification failed");
            $finish;
        end
    end

    // basic replies and the timer life cycle
    task automatic test_actions();
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        send_word(ACT_COUNT, '0, '0, 1'b0, '0);
        send_word(ACT_CANCEL, 32'hFFFF_FFFF, '0, 1'b0, '0);
        send_word(ACT_CREATE, '0, '0, 1'b1, '0);            // zero period fails
        a = next_id;
        send_word(ACT_CREATE, '0, 32'hFFFF_FFFF, 1'b1, '0);
        b = next_id;
        send_word(ACT_CREATE, '0, 32'd1, 1'b0, '0);
        send_word(ACT_PAUSE, b, '0, 1'b0, '0);              // idle, cannot pause
        send_word(ACT_START, b, '0, 1'b0, '0);
        send_word(ACT_START, b, '0, 1'b0, '0);              // already running
        send_word(ACT_START, a, '0, 1'b0, '0);
        send_word(ACT_UPDATE, '0, '0, 1'b0, '0);            // nothing expires
        send_word(ACT_PAUSE, a, '0, 1'b0, '0);
        send_word(ACT_PAUSE, a, '0, 1'b0, '0);              // already paused
        send_word(ACT_START, a, '0, 1'b0, '0);              // resume from paused
        send_word(ACT_UPDATE, '0, '0, 1'b0, 32'hFFFF_FFFF); // both expire, one reloads
        send_word(ACT_UPDATE, '0, '0, 1'b0, 32'hFFFF_FFFE); // just short of expiry
        send_word(ACT_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_word(ACT_SPARE7, '0, '0, 1'b0, '0);
        send_word(ACT_CANCEL, a, '0, 1'b0, '0);
        send_word(ACT_CANCEL, a, '0, 1'b0, '0);             // gone already
        send_word(ACT_COUNT, '0, '0, 1'b0, '0);
    endtask

    // fill every slot, overflow, expire in age order, then empty the table
    task automatic test_full_table();
        for (int i = 0; i < SLOTS + 1; i++)
            send_word(ACT_CREATE, '0, 32'($urandom_range(1, 3)), i[0], '0);
        send_word(ACT_COUNT, '0, '0, 1'b0, '0);
        for (int s = 0; s < SLOTS; s++)
            send_word(ACT_START, tmr_id[s], '0, 1'b0, '0);
        send_word(ACT_UPDATE, '0, '0, 1'b0, 32'd3);
        send_word(ACT_UPDATE, '0, '0, 1'b0, 32'd2);
        for (int s = 0; s < SLOTS; s++)
            if (tmr_used[s])
                send_word(ACT_CANCEL, tmr_id[s], '0, 1'b0, '0);
        send_word(ACT_COUNT, '0, '0, 1'b0, '0);
    endtask

    // one random action; start, pause and cancel mostly aimed at live timers
    task automatic random_action();
        int r;
        logic [TICK_W-1:0] per;
        logic [TICK_W-1:0] el;
        r = $urandom_range(99);
        per = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(1, 60));
        if ($urandom_range(11) == 0)
            per = '0;
        el = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
        if (r < 22)
            send_word(ACT_CREATE, $urandom, per, 1'($urandom), $urandom);
        else if (r < 40)
            send_word(ACT_START, live_id(), $urandom, 1'($urandom), $urandom);
        else if (r < 50)
            send_word(ACT_PAUSE, live_id(), $urandom, 1'($urandom), $urandom);
        else if (r < 58)
            send_word(ACT_CANCEL, live_id(), $urandom, 1'($urandom), $urandom);
        else if (r < 63)
            send_word(ACT_LIMIT_PICK(r), $urandom, $urandom, 1'($urandom), $urandom);
        else if (r < 88)
            send_word(ACT_UPDATE, $urandom, $urandom, 1'($urandom), el);
        else if (r < 95)
            send_word(ACT_COUNT, $urandom, $urandom, 1'($urandom), $urandom);
        else
            send_word(r[0] ? ACT_SPARE7 : ACT_SPARE6, $urandom, $urandom,
                      1'($urandom), $urandom);
    endtask

    // start, pause or cancel on an id picked at random
    function automatic logic [ACT_W-1:0] ACT_LIMIT_PICK(int r);
        case (r % 3)
            0: return ACT_START;
            1: return ACT_PAUSE;
            default: return ACT_CANCEL;
        endcase
    endfunction

    // random traffic under one idling setting
    task automatic test_random(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            random_action();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_CREATE;
        m_tready       = 1'b0;
        fail_count     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        next_id        = 1;
        for (int s = 0; s < SLOTS; s++)
        begin
            tmr_used[s] = 1'b0;
            tmr_rank[s] = 0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_actions();
        test_full_table();
        drain();
        test_random(11, 69, 110);
        drain();
        test_random(69, 11, 110);
        test_random(0, 0, 110);

        drain();
        if (fail_count == 0)
            $display("multi_slot_software_timer_table verification clean");
        else
            $display("multi_slot_software_timer_table verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mstt_pkg.sv
hw/rtl/mstt_ram.sv
hw/rtl/mstt_ctrl.sv
hw/rtl/mstt_out.sv
hw/rtl/multi_slot_software_timer_table.sv
hw/rtl/mstt_checker.sv
dv/tb_multi_slot_software_timer_table.sv
